[rtl/hsfc_pkg.sv]
// Shared constants, types and CRC-8 step for the sensor frame checker.
package hsfc_pkg;

  localparam int FRAME_BYTES = 6;
  localparam int POS_W = 3;

  localparam logic [7:0] CRC_INIT = 8'hFF;
  localparam logic [7:0] CRC_POLY = 8'h31;

  localparam logic [POS_W-1:0] POS_HI0  = 3'd0;
  localparam logic [POS_W-1:0] POS_LO0  = 3'd1;
  localparam logic [POS_W-1:0] POS_CRC0 = 3'd2;
  localparam logic [POS_W-1:0] POS_HI1  = 3'd3;
  localparam logic [POS_W-1:0] POS_LO1  = 3'd4;
  localparam logic [POS_W-1:0] POS_CRC1 = 3'd5;
  localparam logic [POS_W-1:0] POS_LAST = POS_W'(FRAME_BYTES);

  localparam logic [12:0] TEMP_MUL = 13'd4375;
  localparam logic [14:0] TEMP_OFS = 15'd4500;
  localparam logic [9:0]  HUM_MUL  = 10'd625;
  localparam int TEMP_SHIFT = 14;
  localparam int HUM_SHIFT  = 12;

  typedef struct packed {
    logic [15:0] first_word;
    logic [15:0] second_word;
    logic        crc_err;
  } frame_t;

  function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

[rtl/hsfc_tracker.sv]
// Byte position tracking, word assembly and per-word CRC check.
module hsfc_tracker (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic [7:0]     in_rx_byte,
  input  logic           in_frame_start,
  output logic           frm_valid,
  input  logic           frm_ready,
  output hsfc_pkg::frame_t frm
);
  import hsfc_pkg::*;

  logic [POS_W-1:0] pos_r, pos_nxt, pos_eff;
  logic [7:0]       crc_r, crc_nxt, crc_base, crc_upd;
  logic [7:0]       hi_r, hi_nxt;
  logic [15:0]      w1_r, w1_nxt;
  logic [15:0]      w2_r, w2_nxt;
  logic             good_r, good_nxt;
  logic             frm_valid_r, frm_valid_nxt;
  frame_t           frm_r, frm_nxt;
  logic             restart, accept, emit;

  assign restart  = in_frame_start || (pos_r >= POS_LAST);
  assign pos_eff  = restart ? POS_HI0 : pos_r;
  assign crc_base = restart ? CRC_INIT : crc_r;
  assign crc_upd  = crc8_step(crc_base, in_rx_byte);

  // Stall only when a frame could complete while the result slot is full.
  assign in_ready = (pos_r != POS_CRC1) || !frm_valid_r || frm_ready;
  assign accept   = in_valid && in_ready;
  assign emit     = accept && (pos_eff == POS_CRC1);

  always_comb begin
    pos_nxt  = pos_r;
    crc_nxt  = crc_r;
    hi_nxt   = hi_r;
    w1_nxt   = w1_r;
    w2_nxt   = w2_r;
    good_nxt = good_r;
    frm_nxt  = frm_r;
    if (accept) begin
      unique case (pos_eff)
        POS_HI0, POS_HI1: begin
          crc_nxt = crc_upd;
          hi_nxt  = in_rx_byte;
          pos_nxt = pos_eff + 1'b1;
        end
        POS_LO0: begin
          crc_nxt = crc_upd;
          w1_nxt  = {hi_r, in_rx_byte};
          pos_nxt = POS_CRC0;
        end
        POS_CRC0: begin
          good_nxt = (crc_base == in_rx_byte);
          crc_nxt  = CRC_INIT;
          pos_nxt  = POS_HI1;
        end
        POS_LO1: begin
          crc_nxt = crc_upd;
          w2_nxt  = {hi_r, in_rx_byte};
          pos_nxt = POS_CRC1;
        end
        default: begin
          frm_nxt.first_word  = w1_r;
          frm_nxt.second_word = w2_r;
          frm_nxt.crc_err     = !(good_r && (crc_base == in_rx_byte));
          crc_nxt = CRC_INIT;
          pos_nxt = POS_HI0;
        end
      endcase
    end
  end

  always_comb begin
    frm_valid_nxt = frm_valid_r;
    if (frm_ready) begin
      frm_valid_nxt = 1'b0;
    end
    if (emit) begin
      frm_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= POS_HI0;
      crc_r       <= CRC_INIT;
      hi_r        <= '0;
      w1_r        <= '0;
      w2_r        <= '0;
      good_r      <= 1'b0;
      frm_valid_r <= 1'b0;
    end else begin
      pos_r       <= pos_nxt;
      crc_r       <= crc_nxt;
      hi_r        <= hi_nxt;
      w1_r        <= w1_nxt;
      w2_r        <= w2_nxt;
      good_r      <= good_nxt;
      frm_valid_r <= frm_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    frm_r <= frm_nxt;
  end

  assign frm_valid = frm_valid_r;
  assign frm       = frm_r;

endmodule

[rtl/hsfc_convert.sv]
// Fixed-point conversion of the frame words and the result register.
module hsfc_convert (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 frm_valid,
  output logic                 frm_ready,
  input  hsfc_pkg::frame_t     frm,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [15:0]          out_first_word,
  output logic [15:0]          out_second_word,
  output logic [31:0]          out_serial_number,
  output logic                 out_frame_status,
  output logic signed [14:0]   out_temperature_centi,
  output logic [13:0]          out_humidity_centi
);
  import hsfc_pkg::*;

  logic [28:0] temp_prod;
  logic [25:0] hum_prod;
  logic [14:0] temp_nxt;
  logic [13:0] hum_nxt;
  logic        valid_r;
  frame_t      frm_r;
  logic [14:0] temp_r;
  logic [13:0] hum_r;

  assign temp_prod = 29'(frm.first_word) * 29'(TEMP_MUL);
  assign hum_prod  = 26'(frm.second_word) * 26'(HUM_MUL);
  assign temp_nxt  = temp_prod[TEMP_SHIFT +: 15] - TEMP_OFS;
  assign hum_nxt   = hum_prod[HUM_SHIFT +: 14];

  assign frm_ready = !valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (frm_ready) begin
      valid_r <= frm_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (frm_ready && frm_valid) begin
      frm_r  <= frm;
      temp_r <= temp_nxt;
      hum_r  <= hum_nxt;
    end
  end

  assign out_valid             = valid_r;
  assign out_first_word        = frm_r.first_word;
  assign out_second_word       = frm_r.second_word;
  assign out_serial_number     = {frm_r.first_word, frm_r.second_word};
  assign out_frame_status      = frm_r.crc_err;
  assign out_temperature_centi = signed'(temp_r);
  assign out_humidity_centi    = hum_r;

endmodule

[rtl/humidity_sensor_frame_checker.sv]
// Top level of the six-byte sensor response frame checker.
// Throughput: one byte item per cycle while in_ready is high; one result per six-byte frame.
// After the frame's last byte is taken, the result passes the CRC tracker register
// and then the conversion register before it is valid at the output.
// Input stalls only at a frame's last byte while both result stages are full.
// Reset (rst_n low, synchronous) clears position, CRC to 0xFF and holds.
module humidity_sensor_frame_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_rx_byte,
  input  logic               in_frame_start,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [15:0]        out_first_word,
  output logic [15:0]        out_second_word,
  output logic [31:0]        out_serial_number,
  output logic               out_frame_status,
  output logic signed [14:0] out_temperature_centi,
  output logic [13:0]        out_humidity_centi
);
  import hsfc_pkg::*;

  logic   frm_valid;
  logic   frm_ready;
  frame_t frm;

  hsfc_tracker u_tracker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_rx_byte     (in_rx_byte),
    .in_frame_start (in_frame_start),
    .frm_valid      (frm_valid),
    .frm_ready      (frm_ready),
    .frm            (frm)
  );

  hsfc_convert u_convert (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .frm_valid             (frm_valid),
    .frm_ready             (frm_ready),
    .frm                   (frm),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_first_word        (out_first_word),
    .out_second_word       (out_second_word),
    .out_serial_number     (out_serial_number),
    .out_frame_status      (out_frame_status),
    .out_temperature_centi (out_temperature_centi),
    .out_humidity_centi    (out_humidity_centi)
  );

endmodule
